[src/mme_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    // Width of one operand or result word.
    localparam int WORD_W = 32;

    // Largest number of result words a run delivers.
    localparam int RESULT_CAP = 16;

    // Operand word count register.
    localparam int OPW_W = 5;
    localparam logic [OPW_W-1:0] OPW_RESET = 5'd16;

    // Register select bit of the configuration address.
    localparam logic REG_OP_WORDS = 1'b0;

    // Request codes on the input channel.
    typedef enum logic [1:0] {
        REQ_BASE  = 2'd0,
        REQ_EXP   = 2'd1,
        REQ_MOD   = 2'd2,
        REQ_START = 2'd3
    } t_req;

    // Write control toward the operand store.
    typedef struct packed {
        logic en;
        t_req kind;
    } t_wr_ctl;

endpackage

`default_nettype wire

[src/mme_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel: operand word loads and start.
interface mme_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [3:0]                word_index;
    logic [mme_pkg::WORD_W-1:0] word_data;

    modport source (output valid, output req_type, output word_index, output word_data,
                    input ready);
    modport sink (input valid, input req_type, input word_index, input word_data,
                  output ready);
endinterface

// Result channel: one word of the power per transfer.
interface mme_out_if;
    logic                      valid;
    logic                      ready;
    logic [mme_pkg::WORD_W-1:0] result_word;
    logic [3:0]                result_index;
    logic                      last;
    logic                      status;

    modport source (output valid, output result_word, output result_index, output last,
                    output status, input ready);
    modport sink (input valid, input result_word, input result_index, input last,
                  input status, output ready);
endinterface

`default_nettype wire

[src/mme_opstore.sv]
`timescale 1ns / 1ps
`default_nettype none

// Base, exponent and modulus word stores with one shared read address.
module mme_opstore #(
    parameter int MAX_WORDS = 16,
    parameter int AW        = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mme_pkg::t_wr_ctl            i_wr,
    input  wire logic [AW-1:0]               i_waddr,
    input  wire logic [mme_pkg::WORD_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]               i_raddr,
    output logic      [mme_pkg::WORD_W-1:0]  o_rd_b,
    output logic      [mme_pkg::WORD_W-1:0]  o_rd_e,
    output logic      [mme_pkg::WORD_W-1:0]  o_rd_n
);

    logic [mme_pkg::WORD_W-1:0] r_mem_b [MAX_WORDS];
    logic [mme_pkg::WORD_W-1:0] r_mem_e [MAX_WORDS];
    logic [mme_pkg::WORD_W-1:0] r_mem_n [MAX_WORDS];
    logic [MAX_WORDS-1:0]       r_vld_b;
    logic [MAX_WORDS-1:0]       r_vld_e;
    logic [MAX_WORDS-1:0]       r_vld_n;

    // Written flags; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= '0;
            r_vld_e <= '0;
            r_vld_n <= '0;
        end else if (i_wr.en) begin
            case (i_wr.kind)
                mme_pkg::REQ_BASE: r_vld_b[i_waddr] <= 1'b1;
                mme_pkg::REQ_EXP:  r_vld_e[i_waddr] <= 1'b1;
                mme_pkg::REQ_MOD:  r_vld_n[i_waddr] <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Word arrays.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            case (i_wr.kind)
                mme_pkg::REQ_BASE: r_mem_b[i_waddr] <= i_wdata;
                mme_pkg::REQ_EXP:  r_mem_e[i_waddr] <= i_wdata;
                mme_pkg::REQ_MOD:  r_mem_n[i_waddr] <= i_wdata;
                default: begin
                end
            endcase
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        o_rd_b <= r_vld_b[i_raddr] ? r_mem_b[i_raddr] : '0;
        o_rd_e <= r_vld_e[i_raddr] ? r_mem_e[i_raddr] : '0;
        o_rd_n <= r_vld_n[i_raddr] ? r_mem_n[i_raddr] : '0;
    end

endmodule

`default_nettype wire

[src/mme_addsub.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared wide adder and subtractor for all modular steps.
module mme_addsub #(
    parameter int W = 514
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic         i_sub,
    output logic      [W-1:0] o_sum
);

    logic [W-1:0] w_b;

    // Two's complement subtract folds the carry in.
    assign w_b   = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + w_b + {{(W-1){1'b0}}, i_sub};

endmodule

`default_nettype wire

[src/montgomery_modular_exponentiation.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Transfer moves
// i_in      sink    one load word (base, exponent, modulus) or a start request
// o_out     source  one result word, least significant first, last marked
// APB       slave   op_words at byte address 0
//
// A load writes one operand word. A start runs a sweep that loads the operands, a
// reduction of the base (L = 32*MAX_WORDS), then a scan of the exponent bits with
// Montgomery squares and multiplies, all on one (L+2)-bit adder. Input ready is high
// only while idle. Reset is synchronous and clears the store's written flags, so
// unwritten words read as zero. Results wait on output ready.
module montgomery_modular_exponentiation #(
    parameter int MAX_WORDS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mme_in_if.sink          i_in,
    mme_out_if.source       o_out,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic            pready
);

    localparam int L   = mme_pkg::WORD_W * MAX_WORDS;
    localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW  = $clog2(2 * L + 1);
    localparam int CAP = (MAX_WORDS < mme_pkg::RESULT_CAP) ? MAX_WORDS : mme_pkg::RESULT_CAP;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_CHK  = 9'b000000100,
        S_RED  = 9'b000001000,
        S_SCAN = 9'b000010000,
        S_PRE  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_FIX  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        MOP_SQR = 2'd0,
        MOP_MUL = 2'd1,
        MOP_FIN = 2'd2
    } t_mop;

    t_state r_state;
    t_mop   r_op;
    logic [mme_pkg::OPW_W-1:0] r_op_words;
    logic [mme_pkg::OPW_W-1:0] r_eff;
    logic [mme_pkg::OPW_W-1:0] r_oidx;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_ecnt;
    logic r_err, r_started, r_pend, r_ov, r_rdv, r_rdm;

    logic [L-1:0] r_n, r_b, r_e, r_x, r_a, r_m;
    logic [L:0]   r_t, r_bn;

    logic [mme_pkg::OPW_W-1:0] w_eff;
    logic [6:0]    w_idx;
    logic          w_in_fire, w_out_fire, w_last;
    mme_pkg::t_req w_req;
    mme_pkg::t_wr_ctl w_wr;
    logic [AW-1:0] w_raddr;
    logic [mme_pkg::WORD_W-1:0] w_rd_b, w_rd_e, w_rd_n;
    logic [L+1:0]  w_op_a, w_op_b, w_sum;
    logic          w_sub, w_neg, w_qbit;
    logic [L:0]    w_addend;
    logic [L-1:0]  w_red, w_fix;

    // Handshakes.
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_req      = mme_pkg::t_req'(i_in.req_type);
    assign w_idx      = {3'b000, i_in.word_index};

    // Effective word count: zero acts as one, saturate at the cap.
    always_comb begin
        if (r_op_words == '0) begin
            w_eff = mme_pkg::OPW_W'(1);
        end else if (r_op_words > mme_pkg::OPW_W'(CAP)) begin
            w_eff = mme_pkg::OPW_W'(CAP);
        end else begin
            w_eff = r_op_words;
        end
    end

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mme_pkg::REG_OP_WORDS) ? {27'd0, r_op_words} : 32'd0;

    // Operand store: loads write while idle, the start sweep reads top word first.
    assign w_wr.en   = w_in_fire && (w_req != mme_pkg::REQ_START) &&
                       (w_idx < 7'(MAX_WORDS));
    assign w_wr.kind = w_req;
    assign w_raddr   = AW'(MAX_WORDS - 1) - r_cnt[AW-1:0];

    mme_opstore #(
        .MAX_WORDS (MAX_WORDS),
        .AW        (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_waddr (w_idx[AW-1:0]),
        .i_wdata (i_in.word_data),
        .i_raddr (w_raddr),
        .o_rd_b  (w_rd_b),
        .o_rd_e  (w_rd_e),
        .o_rd_n  (w_rd_n)
    );

    // Operand select for the shared adder.
    assign w_qbit = r_t[0] ^ (r_a[0] & r_m[0]);

    always_comb begin
        case ({r_a[0], w_qbit})
            2'b10:   w_addend = {1'b0, r_m};
            2'b01:   w_addend = {1'b0, r_n};
            2'b11:   w_addend = r_bn;
            default: w_addend = '0;
        endcase
    end

    always_comb begin
        case (r_state)
            S_RED: begin
                w_op_a = {1'b0, r_t[L-1:0], r_b[L-1]};
                w_op_b = {2'b00, r_n};
                w_sub  = 1'b1;
            end
            S_PRE: begin
                w_op_a = {2'b00, r_m};
                w_op_b = {2'b00, r_n};
                w_sub  = 1'b0;
            end
            S_MUL: begin
                w_op_a = {1'b0, r_t};
                w_op_b = {1'b0, w_addend};
                w_sub  = 1'b0;
            end
            S_FIX: begin
                w_op_a = {1'b0, r_t};
                w_op_b = {2'b00, r_n};
                w_sub  = 1'b1;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
                w_sub  = 1'b0;
            end
        endcase
    end

    mme_addsub #(
        .W (L + 2)
    ) u_addsub (
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .i_sub (w_sub),
        .o_sum (w_sum)
    );

    // Keep the difference only when it did not go negative.
    assign w_neg = w_sum[L+1];
    assign w_red = w_neg ? {r_t[L-2:0], r_b[L-1]} : w_sum[L-1:0];
    assign w_fix = w_neg ? r_t[L-1:0] : w_sum[L-1:0];

    assign w_last = (r_oidx == (r_eff - mme_pkg::OPW_W'(1)));

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= MOP_SQR;
            r_op_words <= mme_pkg::OPW_RESET;
            r_eff      <= mme_pkg::OPW_W'(1);
            r_oidx     <= '0;
            r_cnt      <= '0;
            r_ecnt     <= '0;
            r_err      <= 1'b0;
            r_started  <= 1'b0;
            r_pend     <= 1'b0;
            r_ov       <= 1'b0;
            r_rdv      <= 1'b0;
            r_rdm      <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready &&
                (paddr[2] == mme_pkg::REG_OP_WORDS)) begin
                r_op_words <= pwdata[mme_pkg::OPW_W-1:0];
            end
            r_rdv <= (r_state == S_LOAD) && (r_cnt < CW'(MAX_WORDS));
            r_rdm <= (7'(w_raddr) < 7'(r_eff));
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire && (w_req == mme_pkg::REQ_START)) begin
                        r_state <= S_LOAD;
                        r_cnt   <= '0;
                        r_err   <= 1'b0;
                        r_eff   <= w_eff;
                    end
                end
                S_LOAD: begin
                    if (r_cnt == CW'(MAX_WORDS)) begin
                        r_state <= S_CHK;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_CHK: begin
                    if (!r_n[0]) begin
                        r_err   <= 1'b1;
                        r_state <= S_OUT;
                        r_ov    <= 1'b1;
                        r_oidx  <= '0;
                    end else begin
                        r_state <= S_RED;
                        r_cnt   <= '0;
                    end
                end
                S_RED: begin
                    if (r_cnt == CW'(2 * L - 1)) begin
                        r_state   <= S_SCAN;
                        r_ecnt    <= CW'(L);
                        r_started <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SCAN: begin
                    if (r_ecnt == '0) begin
                        if (r_started) begin
                            r_op    <= MOP_FIN;
                            r_state <= S_PRE;
                        end else begin
                            r_state <= S_OUT;
                            r_ov    <= 1'b1;
                            r_oidx  <= '0;
                        end
                    end else begin
                        r_ecnt <= r_ecnt - CW'(1);
                        if (!r_started) begin
                            if (r_e[L-1]) begin
                                r_started <= 1'b1;
                            end
                        end else begin
                            r_op    <= MOP_SQR;
                            r_pend  <= r_e[L-1];
                            r_state <= S_PRE;
                        end
                    end
                end
                S_PRE: begin
                    r_state <= S_MUL;
                    r_cnt   <= '0;
                end
                S_MUL: begin
                    if (r_cnt == CW'(L - 1)) begin
                        r_state <= S_FIX;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_FIX: begin
                    if ((r_op == MOP_SQR) && r_pend) begin
                        r_op    <= MOP_MUL;
                        r_state <= S_PRE;
                    end else if (r_op == MOP_FIN) begin
                        r_state <= S_OUT;
                        r_ov    <= 1'b1;
                        r_oidx  <= '0;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_OUT: begin
                    if (w_out_fire) begin
                        r_oidx <= r_oidx + mme_pkg::OPW_W'(1);
                        if (w_last) begin
                            r_ov    <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Wide datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_rdv) begin
            r_n <= (r_n << mme_pkg::WORD_W) | L'(r_rdm ? w_rd_n : '0);
            r_b <= (r_b << mme_pkg::WORD_W) | L'(r_rdm ? w_rd_b : '0);
            r_e <= (r_e << mme_pkg::WORD_W) | L'(r_rdm ? w_rd_e : '0);
        end
        case (r_state)
            S_CHK: begin
                r_t <= '0;
            end
            S_RED: begin
                // r = 2r + bit mod N; base bits then zeros give base*R mod N.
                r_t <= {1'b0, w_red};
                if (r_cnt == CW'(2 * L - 1)) begin
                    r_b <= w_red;
                end else begin
                    r_b <= r_b << 1;
                end
            end
            S_SCAN: begin
                if (r_ecnt == '0) begin
                    if (r_started) begin
                        r_a <= r_x;
                        r_m <= L'(1);
                        r_t <= '0;
                    end else begin
                        r_x <= (r_n == L'(1)) ? '0 : L'(1);
                    end
                end else begin
                    r_e <= r_e << 1;
                    if (!r_started) begin
                        if (r_e[L-1]) begin
                            r_x <= r_b;
                        end
                    end else begin
                        r_a <= r_x;
                        r_m <= r_x;
                        r_t <= '0;
                    end
                end
            end
            S_PRE: begin
                r_bn <= w_sum[L:0];
            end
            S_MUL: begin
                // One radix-2 Montgomery step: add, then halve.
                r_t <= w_sum[L+1:1];
                r_a <= r_a >> 1;
            end
            S_FIX: begin
                r_x <= w_fix;
                if ((r_op == MOP_SQR) && r_pend) begin
                    r_a <= w_fix;
                    r_m <= r_b;
                    r_t <= '0;
                end
            end
            S_OUT: begin
                if (w_out_fire) begin
                    r_x <= r_x >> mme_pkg::WORD_W;
                end
            end
            default: begin
            end
        endcase
    end

    // Result channel.
    assign o_out.valid        = r_ov;
    assign o_out.result_word  = r_err ? '0 : r_x[mme_pkg::WORD_W-1:0];
    assign o_out.result_index = r_oidx[3:0];
    assign o_out.last         = w_last;
    assign o_out.status       = r_err;

    a_ov_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_state == S_OUT))
        else $error("result valid outside the output phase");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("request taken while results are pending");

    a_odd_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) |-> r_n[0])
        else $error("reduction started on an even modulus");

    a_x_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_started) |-> (r_x < r_n))
        else $error("running value not reduced below the modulus");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (o_out.result_index == 4'd0))
        else $error("result run does not start at word zero");

endmodule

`default_nettype wire
